// ----- rtl/ltt_pkg.sv -----
// ----------------------------------------------------------------------------
// ltt_pkg
// Shared widths, codes and types of the lease timeout table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ltt_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int CMD_W     = 3;
    localparam int KEY_W     = 63;
    localparam int LEASE_W   = 64;
    localparam int TIME_W    = 32;
    localparam int INT_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RENEW      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RENEW_INTERVAL = 8'd1;
    localparam logic [INT_W-1:0]     LEASE_INTERVAL_RST = 16'd60;
    localparam logic [INT_W-1:0]     RENEW_INTERVAL_RST = 16'd30;

    // one stored table entry
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LEASE_W-1:0] lease;
        logic [TIME_W-1:0]  expiry;
        logic [TIME_W-1:0]  renew_at;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // interval settings
    typedef struct packed {
        logic [INT_W-1:0] lease_interval;
        logic [INT_W-1:0] renew_interval;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic                      found;
        logic signed [LEASE_W-1:0] lease_id_out;
        logic                      lease_valid;
        logic                      renew_due;
        logic [STATUS_W-1:0]       status;
    } t_rsp_word;

endpackage

`default_nettype wire

// ----- rtl/ltt_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ltt_cmd_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ltt_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [ltt_pkg::CMD_W-1:0]          command;
    logic [ltt_pkg::KEY_W-1:0]          chunk_id;
    logic signed [ltt_pkg::LEASE_W-1:0] new_lease_id;

    modport source (output valid, command, chunk_id, new_lease_id, input ready);
    modport sink   (input valid, command, chunk_id, new_lease_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/ltt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ltt_rsp_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ltt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic signed [ltt_pkg::LEASE_W-1:0] lease_id_out;
    logic                               lease_valid;
    logic                               renew_due;
    logic [ltt_pkg::STATUS_W-1:0]       status;

    modport source (output valid, found, lease_id_out, lease_valid, renew_due, status,
                    input ready);
    modport sink   (input valid, found, lease_id_out, lease_valid, renew_due, status,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/ltt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ltt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ltt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ltt_pkg::CFG_IDX_W-1:0] index;
    logic [ltt_pkg::INT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ltt_ram.sv -----
// ----------------------------------------------------------------------------
// ltt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ltt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ltt_ctrl
// Command sequencer: for table commands scans the entry memory, then updates and reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    ltt_cmd_if.sink                 i_cmd,
    input  wire ltt_pkg::t_cfg      i_cfg,
    output      logic               o_res_valid,
    output      ltt_pkg::t_rsp_word o_res,
    input  wire logic               i_res_ready
);

    localparam logic [ltt_pkg::IDX_W-1:0] LAST_IDX = ltt_pkg::IDX_W'(ltt_pkg::ENTRIES - 1);
    localparam logic [ltt_pkg::CNT_W-1:0] END_CNT  = ltt_pkg::CNT_W'(ltt_pkg::ENTRIES);
    localparam int PAD_W = ltt_pkg::TIME_W - ltt_pkg::INT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // latched command word
    logic [ltt_pkg::CMD_W-1:0]          r_command;
    logic [ltt_pkg::KEY_W-1:0]          r_key;
    logic signed [ltt_pkg::LEASE_W-1:0] r_lease;

    // scan pointers
    logic [ltt_pkg::CNT_W-1:0] r_rd_idx;
    logic                      r_chk_vld;
    logic [ltt_pkg::IDX_W-1:0] r_chk_idx;

    // scan results
    logic                      r_hit;
    logic [ltt_pkg::IDX_W-1:0] r_hit_idx;
    ltt_pkg::t_entry           r_hit_ent;
    logic                      r_free;
    logic [ltt_pkg::IDX_W-1:0] r_free_idx;

    // table occupancy and clock
    logic [ltt_pkg::ENTRIES-1:0] r_used;
    logic [ltt_pkg::TIME_W-1:0]  r_now;

    logic                      cmd_fire;
    logic                      res_fire;
    logic                      ram_re;
    logic [ltt_pkg::IDX_W-1:0] ram_raddr;
    logic                      ram_we;
    logic [ltt_pkg::IDX_W-1:0] ram_waddr;
    ltt_pkg::t_entry           ram_wdata;
    logic [ltt_pkg::ENTRY_W-1:0] ram_rdata;
    ltt_pkg::t_entry           rd_ent;
    logic                      chk_used;
    logic                      chk_hit;
    logic                      chk_free;
    logic                      scan_done;
    logic                      is_table_cmd;
    logic [ltt_pkg::TIME_W-1:0] d_exp;
    logic [ltt_pkg::TIME_W-1:0] d_ren;
    logic [ltt_pkg::TIME_W-1:0] new_expiry;
    logic [ltt_pkg::TIME_W-1:0] new_renew;

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign cmd_fire     = i_cmd.valid && i_cmd.ready;
    assign o_res_valid  = (r_state == S_FIN);
    assign res_fire     = o_res_valid && i_res_ready;
    assign is_table_cmd = i_cmd.command inside {ltt_pkg::CMD_REGISTER, ltt_pkg::CMD_UNREGISTER,
                                                ltt_pkg::CMD_RENEW, ltt_pkg::CMD_LOOKUP};

    // entry memory
    ltt_ram #(
        .WIDTH (ltt_pkg::ENTRY_W),
        .DEPTH (ltt_pkg::ENTRIES),
        .AW    (ltt_pkg::IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = ram_rdata;

    // scan read issue
    assign ram_re    = (r_state == S_SCAN) && (r_rd_idx < END_CNT);
    assign ram_raddr = r_rd_idx[ltt_pkg::IDX_W-1:0];

    // compare stage, in the cycle after the read is issued
    assign chk_used  = r_used[r_chk_idx];
    assign chk_hit   = (r_state == S_SCAN) && r_chk_vld && chk_used && !r_hit &&
                       (rd_ent.key == r_key);
    assign chk_free  = (r_state == S_SCAN) && r_chk_vld && !chk_used && !r_free;
    assign scan_done = r_chk_vld && (r_chk_idx == LAST_IDX);

    // new times from the current second
    assign new_expiry = r_now + {{PAD_W{1'b0}}, i_cfg.lease_interval};
    assign new_renew  = r_now + {{PAD_W{1'b0}}, i_cfg.renew_interval};

    // write back
    always_comb begin
        ram_we = 1'b0;
        if (res_fire) begin
            if (r_command == ltt_pkg::CMD_REGISTER) begin
                ram_we = r_hit || r_free;
            end else if (r_command == ltt_pkg::CMD_RENEW) begin
                ram_we = r_hit;
            end
        end
    end

    assign ram_waddr          = r_hit ? r_hit_idx : r_free_idx;
    assign ram_wdata.key      = r_key;
    assign ram_wdata.lease    = (r_command == ltt_pkg::CMD_REGISTER) ? $unsigned(r_lease)
                                                                     : r_hit_ent.lease;
    assign ram_wdata.expiry   = new_expiry;
    assign ram_wdata.renew_at = new_renew;

    // lookup time checks
    assign d_exp = r_now - r_hit_ent.expiry;
    assign d_ren = r_now - r_hit_ent.renew_at;

    // result word
    always_comb begin
        o_res = '0;
        case (r_command)
            ltt_pkg::CMD_REGISTER: begin
                o_res.found  = r_hit;
                o_res.status = (r_hit || r_free) ? ltt_pkg::ST_OK : ltt_pkg::ST_FULL;
            end
            ltt_pkg::CMD_UNREGISTER, ltt_pkg::CMD_RENEW: begin
                o_res.found  = r_hit;
                o_res.status = r_hit ? ltt_pkg::ST_OK : ltt_pkg::ST_NOT_FOUND;
            end
            ltt_pkg::CMD_LOOKUP: begin
                o_res.found        = r_hit;
                o_res.lease_id_out = r_hit ? $signed(r_hit_ent.lease) : '0;
                o_res.lease_valid  = r_hit && ((d_exp == '0) || d_exp[ltt_pkg::TIME_W-1]);
                o_res.renew_due    = !r_hit || !d_ren[ltt_pkg::TIME_W-1];
                o_res.status       = r_hit ? ltt_pkg::ST_OK : ltt_pkg::ST_NOT_FOUND;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_state = is_table_cmd ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (res_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_used    <= '0;
            r_now     <= '0;
            r_rd_idx  <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= ram_re;
            if (cmd_fire) begin
                r_hit    <= 1'b0;
                r_free   <= 1'b0;
                r_rd_idx <= '0;
            end else begin
                if (ram_re) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (chk_hit) begin
                    r_hit <= 1'b1;
                end
                if (chk_free) begin
                    r_free <= 1'b1;
                end
            end
            if (res_fire) begin
                case (r_command)
                    ltt_pkg::CMD_REGISTER: begin
                        if (!r_hit && r_free) begin
                            r_used[r_free_idx] <= 1'b1;
                        end
                    end
                    ltt_pkg::CMD_UNREGISTER: begin
                        if (r_hit) begin
                            r_used[r_hit_idx] <= 1'b0;
                        end
                    end
                    ltt_pkg::CMD_TICK: begin
                        r_now <= r_now + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_command <= i_cmd.command;
            r_key     <= i_cmd.chunk_id;
            r_lease   <= i_cmd.new_lease_id;
        end
        r_chk_idx <= ram_raddr;
        if (chk_hit) begin
            r_hit_idx <= r_chk_idx;
            r_hit_ent <= rd_ent;
        end
        if (chk_free) begin
            r_free_idx <= r_chk_idx;
        end
    end

    // scan pointer never runs past the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= END_CNT))
        else $error("scan pointer past table end");

    // a recorded hit always points at a used entry
    a_hit_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_hit) |-> r_used[r_hit_idx])
        else $error("hit on unused entry");

    // unregister hit frees its entry
    a_unreg_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && r_command == ltt_pkg::CMD_UNREGISTER && r_hit)
        |=> !r_used[$past(r_hit_idx)])
        else $error("unregister left entry used");

    // tick advances the seconds counter by one
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && r_command == ltt_pkg::CMD_TICK) |=> (r_now == $past(r_now) + 1'b1))
        else $error("tick did not advance time");

endmodule

`default_nettype wire

// ----- rtl/lease_timeout_table.sv -----
// ----------------------------------------------------------------------------
// lease_timeout_table
// Bounded lease table keyed by chunk id, with expiry and renewal tracking.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     word
//  i_cmd     in    valid/ready   command, chunk_id, new_lease_id
//  o_rsp     out   valid/ready   found, lease_id_out, lease_valid, renew_due, status
//  i_cfg     in    valid/ready   index, data (interval registers)
//
//  register, unregister, renew and lookup: accept, a scan of the entry memory
//  through its single read port, then update and result.
//  tick and unused codes skip the scan: accept, then update and result.
//  reset clears the used bits and the seconds counter and reloads the
//  default intervals at once.
//  a waiting result sits in the output register; a new word is accepted
//  meanwhile, and its finish cycle holds until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lease_timeout_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ltt_cmd_if.sink   i_cmd,
    ltt_cfg_if.sink   i_cfg,
    ltt_rsp_if.source o_rsp
);

    ltt_pkg::t_cfg      r_cfg;
    ltt_pkg::t_rsp_word r_rsp;
    logic               r_rsp_valid;

    logic               res_valid;
    ltt_pkg::t_rsp_word res_word;
    logic               res_ready;

    // interval registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lease_interval <= ltt_pkg::LEASE_INTERVAL_RST;
            r_cfg.renew_interval <= ltt_pkg::RENEW_INTERVAL_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == ltt_pkg::CFG_LEASE_INTERVAL) begin
                r_cfg.lease_interval <= i_cfg.data;
            end else if (i_cfg.index == ltt_pkg::CFG_RENEW_INTERVAL) begin
                r_cfg.renew_interval <= i_cfg.data;
            end
        end
    end

    // sequencer and entry memory
    ltt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res_word),
        .i_res_ready (res_ready)
    );

    // output register
    assign res_ready = !r_rsp_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_rsp <= res_word;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.found        = r_rsp.found;
    assign o_rsp.lease_id_out = r_rsp.lease_id_out;
    assign o_rsp.lease_valid  = r_rsp.lease_valid;
    assign o_rsp.renew_due    = r_rsp.renew_due;
    assign o_rsp.status       = r_rsp.status;

endmodule

`default_nettype wire
